// File: hdl/spr_pkg.sv
package spr_pkg;

  localparam int SLOT_ENTRY_BYTES = 8;
  localparam logic [15:0] GEN_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_ERASE  = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BEYOND    = 3'd4
  } status_t;

  // which stores the copy engine moves between
  typedef enum logic [1:0] {
    CP_SNAP  = 2'd0,
    CP_MOVE  = 2'd1,
    CP_STAGE = 2'd2
  } cp_sel_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  slot;
    logic [7:0]  data_byte;
    logic [11:0] byte_index;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  slot_out;
    logic [7:0]  read_byte;
    logic [11:0] record_length;
    logic [15:0] slot_gen;
  } out_item_t;

  typedef struct packed {
    logic acc;
    logic eval;
    logic rd_byte;
    logic ins_chk;
    logic scan_chk;
    logic ins_dec;
    logic cp_init;
    logic cp_run;
    logic walk_chk;
    logic walk_wr;
    logic cp_end;
    logic alloc;
    logic dir_wr;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ev_emit;
    logic ev_read;
    logic ev_compact;
    logic too_large;
    logic dir_empty;
    logic scan_hit;
    logic scan_last;
    logic dec_full;
    logic dec_compact;
    logic walk_brk;
    logic walk_move;
    logic cp_done;
    logic out_free;
  } dp_stat_t;

endpackage

// File: hdl/spr_ram.sv
module spr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/spr_ctrl.sv
module spr_ctrl
  import spr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_mode,
  input  logic       in_last,
  output logic       in_stall,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_EVAL     = 18'h00002,
    S_RD_BYTE  = 18'h00004,
    S_INS_CHK  = 18'h00008,
    S_SCAN_RD  = 18'h00010,
    S_SCAN_CHK = 18'h00020,
    S_INS_DEC  = 18'h00040,
    S_CP_INIT  = 18'h00080,
    S_SNAP     = 18'h00100,
    S_WALK_RD  = 18'h00200,
    S_WALK_CHK = 18'h00400,
    S_MOVE     = 18'h00800,
    S_WALK_WR  = 18'h01000,
    S_CP_END   = 18'h02000,
    S_ALLOC    = 18'h04000,
    S_COMMIT   = 18'h08000,
    S_DIR_WR   = 18'h10000,
    S_EMIT     = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_INSERT || in_mode == MODE_UPDATE) begin
            if (in_last) begin
              state_nxt = (in_mode == MODE_INSERT) ? S_INS_CHK : S_EVAL;
            end
          end else begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (stat.ev_emit) state_nxt = S_EMIT;
        else if (stat.ev_read) state_nxt = S_RD_BYTE;
        else if (stat.ev_compact) state_nxt = S_CP_INIT;
        else state_nxt = S_ALLOC;
      end
      S_RD_BYTE: state_nxt = S_EMIT;
      S_INS_CHK: begin
        if (stat.too_large) state_nxt = S_EMIT;
        else if (stat.dir_empty) state_nxt = S_INS_DEC;
        else state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (stat.scan_hit || stat.scan_last) state_nxt = S_INS_DEC;
        else state_nxt = S_SCAN_RD;
      end
      S_INS_DEC: begin
        if (stat.dec_full) state_nxt = S_EMIT;
        else if (stat.dec_compact) state_nxt = S_CP_INIT;
        else state_nxt = S_ALLOC;
      end
      S_CP_INIT: state_nxt = S_SNAP;
      S_SNAP: begin
        if (stat.cp_done) state_nxt = stat.dir_empty ? S_CP_END : S_WALK_RD;
      end
      S_WALK_RD: state_nxt = S_WALK_CHK;
      S_WALK_CHK: begin
        if (stat.walk_brk) state_nxt = S_CP_END;
        else if (stat.walk_move) state_nxt = S_MOVE;
        else if (stat.scan_last) state_nxt = S_CP_END;
        else state_nxt = S_WALK_RD;
      end
      S_MOVE: begin
        if (stat.cp_done) state_nxt = S_WALK_WR;
      end
      S_WALK_WR: state_nxt = stat.scan_last ? S_CP_END : S_WALK_RD;
      S_CP_END: state_nxt = S_ALLOC;
      S_ALLOC: state_nxt = S_COMMIT;
      S_COMMIT: begin
        if (stat.cp_done) state_nxt = S_DIR_WR;
      end
      S_DIR_WR: state_nxt = S_EMIT;
      S_EMIT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.acc      = (state_r == S_IDLE) && in_valid;
    cmd.eval     = (state_r == S_EVAL);
    cmd.rd_byte  = (state_r == S_RD_BYTE);
    cmd.ins_chk  = (state_r == S_INS_CHK);
    cmd.scan_chk = (state_r == S_SCAN_CHK);
    cmd.ins_dec  = (state_r == S_INS_DEC);
    cmd.cp_init  = (state_r == S_CP_INIT);
    cmd.cp_run   = (state_r == S_SNAP) || (state_r == S_MOVE) || (state_r == S_COMMIT);
    cmd.walk_chk = (state_r == S_WALK_CHK);
    cmd.walk_wr  = (state_r == S_WALK_WR);
    cmd.cp_end   = (state_r == S_CP_END);
    cmd.alloc    = (state_r == S_ALLOC);
    cmd.dir_wr   = (state_r == S_DIR_WR);
    cmd.emit     = (state_r == S_EMIT) && stat.out_free;
  end

endmodule

// File: hdl/spr_dp.sv
module spr_dp
  import spr_pkg::*;
#(
  parameter int PAGE_BYTES       = 4096,
  parameter int HEADER_BYTES     = 28,
  parameter int MAX_RECORD_BYTES = 4060,
  parameter int MAX_SLOTS        = 512
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_item,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat
);

  localparam int VW = $clog2(PAGE_BYTES + MAX_RECORD_BYTES + HEADER_BYTES +
                             MAX_SLOTS * SLOT_ENTRY_BYTES + 1) + 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int DDEPTH = (MAX_SLOTS > 1) ? MAX_SLOTS : 2;
  localparam int AW = $clog2(PAGE_BYTES);
  localparam int DW = 3 * VW + 16;

  localparam logic [VW-1:0] PAGE_V  = VW'(PAGE_BYTES);
  localparam logic [VW-1:0] HDR_V   = VW'(HEADER_BYTES);
  localparam logic [VW-1:0] MAXR_V  = VW'(MAX_RECORD_BYTES);
  localparam logic [VW-1:0] MAXS_V  = VW'(MAX_SLOTS);
  localparam logic [VW-1:0] ENTRY_V = VW'(SLOT_ENTRY_BYTES);

  // item and bookkeeping
  logic [1:0]    mode_r, mode_nxt;
  logic [8:0]    slot_r, slot_nxt;
  logic [11:0]   idx_r, idx_nxt;
  logic [VW-1:0] len_r, len_nxt;
  logic [VW-1:0] stg_len_r, stg_len_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [VW-1:0] fre_r, fre_nxt;
  logic [VW-1:0] live_r, live_nxt;
  logic [CW-1:0] dir_i_r, dir_i_nxt;
  logic [VW-1:0] dest_r, dest_nxt;
  logic [DW-1:0] ent_r, ent_nxt;
  // commit target
  logic [CW-1:0] tgt_slot_r, tgt_slot_nxt;
  logic [VW-1:0] tgt_off_r, tgt_off_nxt;
  logic [15:0]   tgt_gen_r, tgt_gen_nxt;
  logic          need_alloc_r, need_alloc_nxt;
  logic          new_slot_r, new_slot_nxt;
  logic          reuse_r, reuse_nxt;
  // copy engine
  cp_sel_t       cp_sel_r, cp_sel_nxt;
  logic [VW-1:0] cp_rd_r, cp_rd_nxt;
  logic [VW-1:0] cp_wr_r, cp_wr_nxt;
  logic [VW-1:0] cp_left_r, cp_left_nxt;
  logic          cp_pend_r, cp_pend_nxt;
  // result
  out_item_t     res_r, res_nxt;
  out_item_t     out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  // memories
  logic [DW-1:0] dir_rdata, dir_wdata;
  logic [SW-1:0] dir_raddr, dir_waddr;
  logic          dir_we;
  logic [7:0]    store_rdata, store_wdata, copy_rdata, stg_rdata;
  logic [AW-1:0] store_raddr;
  logic          store_we, copy_we, stg_we;

  // directory entry fields
  logic [VW-1:0] e_off, e_size, e_cap;
  logic [15:0]   e_gen;
  assign e_off  = dir_rdata[VW-1:0];
  assign e_size = dir_rdata[2*VW-1:VW];
  assign e_cap  = dir_rdata[3*VW-1:2*VW];
  assign e_gen  = dir_rdata[DW-1:3*VW];

  logic [VW-1:0] start_v, free_v, alloc_v, dead_v, pos_v, req_v, walk_dst, alloc_off;
  logic [VW-1:0] stg_inc;
  logic          slot_in, live_s, rd_ok, too_large, resize, upd_full;
  logic          is_erase, is_read, is_upd;
  logic [15:0]   ev_gen;

  assign start_v = HDR_V + VW'(count_r) * ENTRY_V;
  assign free_v  = (fre_r > start_v) ? fre_r - start_v : '0;
  assign alloc_v = PAGE_V - fre_r;
  assign dead_v  = (alloc_v > live_r) ? alloc_v - live_r : '0;
  assign pos_v   = e_off + VW'(idx_r);

  assign slot_in   = VW'(slot_r) < VW'(count_r);
  assign live_s    = slot_in && (e_size != '0);
  assign ev_gen    = slot_in ? e_gen : 16'd0;
  assign rd_ok     = (VW'(idx_r) < e_size) && (pos_v < PAGE_V);
  assign too_large = len_r > MAXR_V;
  assign resize    = len_r != e_cap;
  assign upd_full  = len_r > free_v + dead_v + e_cap;
  assign is_erase  = (mode_r == MODE_ERASE);
  assign is_read   = (mode_r == MODE_READ);
  assign is_upd    = (mode_r == MODE_UPDATE);
  assign req_v     = len_r + (reuse_r ? '0 : ENTRY_V);
  assign walk_dst  = dest_r - e_cap;
  assign alloc_off = need_alloc_r ? fre_r - len_r : tgt_off_r;
  assign stg_inc   = (stg_len_r <= MAXR_V) ? stg_len_r + 1'b1 : stg_len_r;

  always_comb begin
    stat             = '0;
    stat.ev_emit     = !live_s || is_erase || (is_read && !rd_ok) ||
                       (is_upd && (too_large || (resize && upd_full)));
    stat.ev_read     = live_s && is_read && rd_ok;
    stat.ev_compact  = live_s && is_upd && !too_large && resize && !upd_full;
    stat.too_large   = too_large;
    stat.dir_empty   = (count_r == '0);
    stat.scan_hit    = (e_size == '0) && (e_gen != GEN_MAX);
    stat.scan_last   = (VW'(dir_i_r) + 1'b1) >= VW'(count_r);
    stat.dec_full    = (!reuse_r && (VW'(count_r) >= MAXS_V)) ||
                       ((req_v > free_v) && (req_v > free_v + dead_v));
    stat.dec_compact = req_v > free_v;
    stat.walk_brk    = (e_size != '0) && (e_cap > dest_r);
    stat.walk_move   = (e_size != '0) && (e_cap <= dest_r) && (e_off != walk_dst) &&
                       (e_off + e_cap <= PAGE_V);
    stat.cp_done     = (cp_left_r == '0) && !cp_pend_r;
    stat.out_free    = !out_valid_r || !out_stall;
  end

  always_comb begin
    mode_nxt       = mode_r;
    slot_nxt       = slot_r;
    idx_nxt        = idx_r;
    len_nxt        = len_r;
    stg_len_nxt    = stg_len_r;
    count_nxt      = count_r;
    fre_nxt        = fre_r;
    live_nxt       = live_r;
    dir_i_nxt      = dir_i_r;
    dest_nxt       = dest_r;
    ent_nxt        = ent_r;
    tgt_slot_nxt   = tgt_slot_r;
    tgt_off_nxt    = tgt_off_r;
    tgt_gen_nxt    = tgt_gen_r;
    need_alloc_nxt = need_alloc_r;
    new_slot_nxt   = new_slot_r;
    reuse_nxt      = reuse_r;
    cp_sel_nxt     = cp_sel_r;
    cp_rd_nxt      = cp_rd_r;
    cp_wr_nxt      = cp_wr_r;
    cp_left_nxt    = cp_left_r;
    cp_pend_nxt    = cp_pend_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    dir_we         = 1'b0;
    dir_waddr      = SW'(slot_r);
    dir_wdata      = {e_gen, {(3 * VW){1'b0}}};

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    if (cmd.acc) begin
      mode_nxt = in_item.mode;
      slot_nxt = in_item.slot;
      idx_nxt  = in_item.byte_index;
      if (in_item.mode == MODE_INSERT || in_item.mode == MODE_UPDATE) begin
        stg_len_nxt = stg_inc;
        if (in_item.last) begin
          len_nxt     = stg_inc;
          stg_len_nxt = '0;
        end
      end
    end

    if (cmd.eval) begin
      res_nxt.slot_out      = slot_r;
      res_nxt.read_byte     = 8'd0;
      res_nxt.slot_gen      = ev_gen;
      res_nxt.record_length = e_size[11:0];
      res_nxt.status        = ST_OK;
      if (!live_s) begin
        res_nxt.status        = ST_NOT_FOUND;
        res_nxt.record_length = 12'd0;
      end else if (is_erase) begin
        res_nxt.record_length = 12'd0;
        live_nxt              = live_r - e_cap;
        dir_we                = 1'b1;
      end else if (is_read) begin
        if (!rd_ok) res_nxt.status = ST_BEYOND;
      end else if (too_large) begin
        res_nxt.status = ST_TOO_LARGE;
      end else if (resize) begin
        if (upd_full) begin
          res_nxt.status = ST_FULL;
        end else begin
          // entry is dropped so compaction closes its hole
          live_nxt       = live_r - e_cap;
          dir_we         = 1'b1;
          tgt_slot_nxt   = CW'(slot_r);
          tgt_gen_nxt    = e_gen;
          need_alloc_nxt = 1'b1;
          new_slot_nxt   = 1'b0;
        end
      end else begin
        tgt_slot_nxt   = CW'(slot_r);
        tgt_gen_nxt    = e_gen;
        tgt_off_nxt    = e_off;
        need_alloc_nxt = 1'b0;
        new_slot_nxt   = 1'b0;
      end
    end

    if (cmd.rd_byte) res_nxt.read_byte = store_rdata;

    if (cmd.ins_chk) begin
      reuse_nxt = 1'b0;
      dir_i_nxt = '0;
      res_nxt   = '0;
      res_nxt.status = ST_TOO_LARGE;
    end

    if (cmd.scan_chk) begin
      if (stat.scan_hit) begin
        reuse_nxt    = 1'b1;
        tgt_slot_nxt = dir_i_r;
        tgt_gen_nxt  = e_gen + 16'd1;
      end else begin
        dir_i_nxt = dir_i_r + 1'b1;
      end
    end

    if (cmd.ins_dec) begin
      res_nxt        = '0;
      res_nxt.status = ST_FULL;
      need_alloc_nxt = 1'b1;
      new_slot_nxt   = !reuse_r;
      if (!reuse_r) begin
        tgt_slot_nxt = count_r;
        tgt_gen_nxt  = 16'd1;
      end
    end

    if (cmd.cp_init) begin
      cp_sel_nxt  = CP_SNAP;
      cp_rd_nxt   = fre_r;
      cp_wr_nxt   = fre_r;
      cp_left_nxt = PAGE_V - fre_r;
      cp_pend_nxt = 1'b0;
      dest_nxt    = PAGE_V;
      dir_i_nxt   = '0;
    end

    if (cmd.cp_run) begin
      if (cp_left_r != '0) begin
        cp_rd_nxt   = cp_rd_r + 1'b1;
        cp_left_nxt = cp_left_r - 1'b1;
        cp_pend_nxt = 1'b1;
      end else begin
        cp_pend_nxt = 1'b0;
      end
      if (cp_pend_r) cp_wr_nxt = cp_wr_r + 1'b1;
    end

    if (cmd.walk_chk) begin
      ent_nxt = dir_rdata;
      if (e_size != '0 && !stat.walk_brk) dest_nxt = walk_dst;
      if (stat.walk_move) begin
        cp_sel_nxt  = CP_MOVE;
        cp_rd_nxt   = e_off;
        cp_wr_nxt   = walk_dst;
        cp_left_nxt = e_cap;
        cp_pend_nxt = 1'b0;
      end else if (!stat.walk_brk) begin
        dir_i_nxt = dir_i_r + 1'b1;
      end
    end

    if (cmd.walk_wr) begin
      dir_we    = 1'b1;
      dir_waddr = SW'(dir_i_r);
      dir_wdata = {ent_r[DW-1:VW], dest_r};
      dir_i_nxt = dir_i_r + 1'b1;
    end

    if (cmd.cp_end) fre_nxt = dest_r;

    if (cmd.alloc) begin
      if (need_alloc_r) fre_nxt = fre_r - len_r;
      if (new_slot_r) count_nxt = count_r + 1'b1;
      tgt_off_nxt = alloc_off;
      cp_sel_nxt  = CP_STAGE;
      cp_rd_nxt   = '0;
      cp_wr_nxt   = alloc_off;
      cp_left_nxt = len_r;
      cp_pend_nxt = 1'b0;
    end

    if (cmd.dir_wr) begin
      dir_we    = 1'b1;
      dir_waddr = SW'(tgt_slot_r);
      dir_wdata = {tgt_gen_r, len_r, len_r, tgt_off_r};
      // a rewrite in place keeps its capacity already counted as live
      if (need_alloc_r) live_nxt = live_r + len_r;
      res_nxt.status        = ST_OK;
      res_nxt.slot_out      = 9'(tgt_slot_r);
      res_nxt.read_byte     = 8'd0;
      res_nxt.record_length = len_r[11:0];
      res_nxt.slot_gen      = tgt_gen_r;
    end

    if (cmd.emit) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_len_r   <= '0;
      count_r     <= '0;
      fre_r       <= PAGE_V;
      live_r      <= '0;
      cp_left_r   <= '0;
      cp_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_len_r   <= stg_len_nxt;
      count_r     <= count_nxt;
      fre_r       <= fre_nxt;
      live_r      <= live_nxt;
      cp_left_r   <= cp_left_nxt;
      cp_pend_r   <= cp_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    slot_r       <= slot_nxt;
    idx_r        <= idx_nxt;
    len_r        <= len_nxt;
    dir_i_r      <= dir_i_nxt;
    dest_r       <= dest_nxt;
    ent_r        <= ent_nxt;
    tgt_slot_r   <= tgt_slot_nxt;
    tgt_off_r    <= tgt_off_nxt;
    tgt_gen_r    <= tgt_gen_nxt;
    need_alloc_r <= need_alloc_nxt;
    new_slot_r   <= new_slot_nxt;
    reuse_r      <= reuse_nxt;
    cp_sel_r     <= cp_sel_nxt;
    cp_rd_r      <= cp_rd_nxt;
    cp_wr_r      <= cp_wr_nxt;
    res_r        <= res_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // memory hookup
  assign dir_raddr   = cmd.acc ? SW'(in_item.slot) : SW'(dir_i_r);
  assign store_raddr = (cmd.cp_run && cp_sel_r == CP_SNAP) ? AW'(cp_rd_r) : AW'(pos_v);
  assign store_we    = cmd.cp_run && cp_pend_r && (cp_sel_r != CP_SNAP);
  assign store_wdata = (cp_sel_r == CP_MOVE) ? copy_rdata : stg_rdata;
  assign copy_we     = cmd.cp_run && cp_pend_r && (cp_sel_r == CP_SNAP);
  assign stg_we      = cmd.acc && (in_item.mode == MODE_INSERT || in_item.mode == MODE_UPDATE) &&
                       (stg_len_r < PAGE_V);

  spr_ram #(.WIDTH(DW), .DEPTH(DDEPTH)) u_dir (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  spr_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (AW'(cp_wr_r)),
    .wdata (store_wdata),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  spr_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_copy (
    .clk   (clk),
    .we    (copy_we),
    .waddr (AW'(cp_wr_r)),
    .wdata (store_rdata),
    .raddr (AW'(cp_rd_r)),
    .rdata (copy_rdata)
  );

  spr_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_stage (
    .clk   (clk),
    .we    (stg_we),
    .waddr (AW'(stg_len_r)),
    .wdata (in_item.data_byte),
    .raddr (AW'(cp_rd_r)),
    .rdata (stg_rdata)
  );

endmodule

// File: hdl/slotted_page_record_manager.sv
// non-final record byte: the controller stays idle, next beat taken in the following cycle
// erase: result register loaded from the directory read; read: directory read, then store read
// commit: an insert first scans directory slots for a free slot, then record bytes are copied from staging
// compaction first snapshots the used region (free region end to page end), then walks the slots and moves records
// one item at a time; a finished result waits in the output register
// reset (rst_n low, synchronous) empties the page; memories are not cleared
module slotted_page_record_manager
  import spr_pkg::*;
#(
  parameter int PAGE_BYTES       = 4096,
  parameter int HEADER_BYTES     = 28,
  parameter int MAX_RECORD_BYTES = 4060,
  parameter int MAX_SLOTS        = 512
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  spr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_item.mode),
    .in_last  (in_item.last),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  spr_dp #(
    .PAGE_BYTES       (PAGE_BYTES),
    .HEADER_BYTES     (HEADER_BYTES),
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
    .MAX_SLOTS        (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("emit did not load the output register");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.acc, cmd.eval, cmd.rd_byte, cmd.ins_chk, cmd.scan_chk, cmd.ins_dec,
              cmd.cp_init, cmd.cp_run, cmd.walk_chk, cmd.walk_wr, cmd.cp_end,
              cmd.alloc, cmd.dir_wr, cmd.emit}))
    else $error("more than one datapath step in a cycle");

  a_byte_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |-> (out_item.read_byte == 8'd0))
    else $error("failed result carries a read byte");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |-> in_stall)
    else $error("input taken while an item is in work");

endmodule
